@@ design/dbscan_point_clustering_assert.svh @@
// ----------------------------------------------------------------------------
// DBSCAN clustering assertion macros
// Short forms for clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef DBSCAN_POINT_CLUSTERING_ASSERT_SVH
`define DBSCAN_POINT_CLUSTERING_ASSERT_SVH

// same-cycle implication
`define DBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dbs_pkg.sv @@
// ----------------------------------------------------------------------------
// DBSCAN clustering package
// Shared widths, label codes, register indexes, job and state types.
// ----------------------------------------------------------------------------
package dbs_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COORD_BITS = 16;

    localparam int CW    = 7;   // counts and labels
    localparam int EPS_W = 35;
    localparam int CFG_AW = 2;

    localparam logic [CW-1:0] LBL_UNCL  = 7'd127;
    localparam logic [CW-1:0] LBL_NOISE = 7'd0;
    localparam logic [CW-1:0] MINP_RST  = 7'd4;

    localparam logic [CFG_AW-1:0] CFG_EPS    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MINPTS = 2'd1;

    typedef struct packed {
        logic [CW-1:0] n;
        logic          ovf;
    } t_job;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SCAN,
        B_SCAN_CHK,
        B_PLOAD,
        B_PLAT,
        B_SWEEP,
        B_DECIDE,
        B_EXP,
        B_EXP_Q,
        B_EXP_L,
        B_EMIT_RD,
        B_EMIT_OUT
    } t_bstate;

endpackage

@@ design/dbs_front.sv @@
// ----------------------------------------------------------------------------
// DBSCAN front end
// Stores incoming points and issues one clustering job per set.
// ----------------------------------------------------------------------------
module dbs_front #(
    parameter int MAX_POINTS = dbs_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = dbs_pkg::DEF_COORD_BITS,
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_acc,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic                         i_set_end,
    output logic                         o_push,
    output dbs_pkg::t_job                o_job,
    input  logic [IW-1:0]                i_rd_addr,
    output logic signed [COORD_BITS-1:0] o_rd_x,
    output logic signed [COORD_BITS-1:0] o_rd_y
);

    logic signed [COORD_BITS-1:0] x_mem [MAX_POINTS];
    logic signed [COORD_BITS-1:0] y_mem [MAX_POINTS];
    logic [dbs_pkg::CW-1:0] r_cnt;
    logic                   r_ovf;
    logic                   room;
    logic [dbs_pkg::CW-1:0] n_cnt;
    logic                   n_ovf;

    assign room  = r_cnt < dbs_pkg::CW'(MAX_POINTS);
    assign n_cnt = room ? r_cnt + 1'b1 : r_cnt;
    assign n_ovf = r_ovf | ~room;

    always_ff @(posedge i_clk) begin
        if (i_acc && room) begin
            x_mem[r_cnt[IW-1:0]] <= i_coord_x;
            y_mem[r_cnt[IW-1:0]] <= i_coord_y;
        end
        o_rd_x <= x_mem[i_rd_addr];
        o_rd_y <= y_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_acc) begin
            // a set_end beat closes the set
            r_cnt <= i_set_end ? '0 : n_cnt;
            r_ovf <= i_set_end ? 1'b0 : n_ovf;
        end
    end

    assign o_push    = i_acc & i_set_end;
    assign o_job.n   = n_cnt;
    assign o_job.ovf = n_ovf;

endmodule

@@ design/dbs_jobq.sv @@
// ----------------------------------------------------------------------------
// DBSCAN job queue
// Two-entry queue of clustering jobs between front and back end.
// ----------------------------------------------------------------------------
module dbs_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dbs_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output dbs_pkg::t_job o_job
);

    dbs_pkg::t_job r_ent [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_fill;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && o_valid) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + 2'(i_push) - 2'(i_pop && o_valid);
        end
    end

    assign o_valid = r_fill != 2'd0;
    assign o_job   = r_ent[r_rp];

endmodule

@@ design/dbs_back.sv @@
// ----------------------------------------------------------------------------
// DBSCAN back end
// Neighbour sweeps, breadth-first cluster growth and label output.
// ----------------------------------------------------------------------------
module dbs_back #(
    parameter int MAX_POINTS = dbs_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = dbs_pkg::DEF_COORD_BITS,
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dbs_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [dbs_pkg::EPS_W-1:0]          i_cfg_data,
    input  logic                               i_job_valid,
    input  dbs_pkg::t_job                      i_job,
    output logic                               o_job_pop,
    output logic                               o_active,
    output logic [IW-1:0]                      o_rd_addr,
    input  logic signed [COORD_BITS-1:0]       i_rd_x,
    input  logic signed [COORD_BITS-1:0]       i_rd_y,
    output logic                               o_strobe,
    output logic [5:0]                         o_load_idx,
    output logic [dbs_pkg::CW-1:0]             o_cluster_label,
    output logic [dbs_pkg::CW-1:0]             o_cluster_count,
    output logic                               o_overflow,
    output logic                               o_last_label
);

    localparam int CW   = dbs_pkg::CW;
    localparam int DXW  = COORD_BITS + 1;
    localparam int SQW  = 2 * DXW;
    localparam int DW   = SQW + 1;
    localparam int CMPW = (DW > dbs_pkg::EPS_W) ? DW : dbs_pkg::EPS_W;

    dbs_pkg::t_bstate r_state, n_state;

    logic [dbs_pkg::EPS_W-1:0] r_eps;
    logic [CW-1:0]             r_minp;

    logic [CW-1:0] r_n, r_i, r_js, r_cnt, r_head, r_tail, r_cid, r_cc, r_e;
    logic          r_ovf, r_enq, r_seed;
    logic [IW-1:0] r_p;
    logic signed [COORD_BITS-1:0] r_px, r_py;

    logic          r_v0, r_v1, r_v2, r_v3;
    logic [IW-1:0] r_j0, r_j1, r_j2, r_j3;
    logic signed [DXW-1:0] r_dx, r_dy;
    logic [SQW-1:0] r_sqx, r_sqy;
    logic           r_hit;
    logic [DW-1:0]  sum;

    logic [CW-1:0] lbl_mem [MAX_POINTS];
    logic [IW-1:0] q_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] r_lvalid, r_qmark;
    logic [CW-1:0] r_lq;
    logic          r_lv;
    logic [IW-1:0] r_qq;

    logic [IW-1:0] lbl_raddr;
    logic          lbl_we;
    logic [CW-1:0] lbl_wdata;
    logic [CW-1:0] lbl_cur;
    logic          issue;
    logic          sweep_done;
    logic          core;

    assign lbl_cur    = r_lv ? r_lq : dbs_pkg::LBL_UNCL;
    assign issue      = (r_state == dbs_pkg::B_SWEEP) && (r_js < r_n);
    assign sweep_done = (r_js == r_n) && !r_v0 && !r_v1 && !r_v2 && !r_v3;
    assign core       = r_cnt >= r_minp;
    assign sum        = DW'(r_sqx) + DW'(r_sqy);

    always_comb begin
        n_state   = r_state;
        lbl_raddr = r_p;
        lbl_we    = 1'b0;
        lbl_wdata = r_cid;
        o_rd_addr = r_p;
        o_job_pop = 1'b0;
        case (r_state)
            dbs_pkg::B_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_state   = dbs_pkg::B_SCAN;
                end
            end
            dbs_pkg::B_SCAN: begin
                lbl_raddr = r_i[IW-1:0];
                n_state   = (r_i == r_n) ? dbs_pkg::B_EMIT_RD : dbs_pkg::B_SCAN_CHK;
            end
            dbs_pkg::B_SCAN_CHK: begin
                n_state = (lbl_cur != dbs_pkg::LBL_UNCL) ? dbs_pkg::B_SCAN : dbs_pkg::B_PLOAD;
            end
            dbs_pkg::B_PLOAD: begin
                n_state = dbs_pkg::B_PLAT;
            end
            dbs_pkg::B_PLAT: begin
                n_state = dbs_pkg::B_SWEEP;
            end
            dbs_pkg::B_SWEEP: begin
                o_rd_addr = r_js[IW-1:0];
                if (sweep_done) begin
                    n_state = dbs_pkg::B_DECIDE;
                end
            end
            dbs_pkg::B_DECIDE: begin
                if (r_enq) begin
                    n_state = dbs_pkg::B_EXP;
                end else if (r_seed) begin
                    lbl_we    = 1'b1;
                    lbl_wdata = core ? r_cc + 1'b1 : dbs_pkg::LBL_NOISE;
                    n_state   = core ? dbs_pkg::B_SWEEP : dbs_pkg::B_SCAN;
                end else begin
                    n_state = core ? dbs_pkg::B_SWEEP : dbs_pkg::B_EXP;
                end
            end
            dbs_pkg::B_EXP: begin
                n_state = (r_head == r_tail) ? dbs_pkg::B_SCAN : dbs_pkg::B_EXP_Q;
            end
            dbs_pkg::B_EXP_Q: begin
                lbl_raddr = r_qq;
                n_state   = dbs_pkg::B_EXP_L;
            end
            dbs_pkg::B_EXP_L: begin
                if (lbl_cur == dbs_pkg::LBL_NOISE) begin
                    lbl_we  = 1'b1;
                    n_state = dbs_pkg::B_EXP;
                end else if (lbl_cur == dbs_pkg::LBL_UNCL) begin
                    lbl_we  = 1'b1;
                    n_state = dbs_pkg::B_PLOAD;
                end else begin
                    n_state = dbs_pkg::B_EXP;
                end
            end
            dbs_pkg::B_EMIT_RD: begin
                lbl_raddr = r_e[IW-1:0];
                n_state   = dbs_pkg::B_EMIT_OUT;
            end
            dbs_pkg::B_EMIT_OUT: begin
                n_state = (r_e + 1'b1 == r_n) ? dbs_pkg::B_IDLE : dbs_pkg::B_EMIT_RD;
            end
            default: begin
                n_state = dbs_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dbs_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // memories and pipeline payload
    always_ff @(posedge i_clk) begin
        if (lbl_we) begin
            lbl_mem[r_p] <= lbl_wdata;
        end
        r_lq <= lbl_mem[lbl_raddr];
        r_lv <= r_lvalid[lbl_raddr];
        r_qq <= q_mem[r_head[IW-1:0]];
        if (r_v3 && r_enq && r_hit && !r_qmark[r_j3] && r_tail < CW'(MAX_POINTS)) begin
            q_mem[r_tail[IW-1:0]] <= r_j3;
        end
        r_j0  <= r_js[IW-1:0];
        r_j1  <= r_j0;
        r_j2  <= r_j1;
        r_j3  <= r_j2;
        r_dx  <= DXW'(r_px) - DXW'(i_rd_x);
        r_dy  <= DXW'(r_py) - DXW'(i_rd_y);
        r_sqx <= $unsigned(SQW'(r_dx) * SQW'(r_dx));
        r_sqy <= $unsigned(SQW'(r_dy) * SQW'(r_dy));
        r_hit <= (CMPW'(sum) < CMPW'(r_eps)) && (r_j2 != r_p);
        if (r_state == dbs_pkg::B_PLAT) begin
            r_px <= i_rd_x;
            r_py <= i_rd_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps    <= '0;
            r_minp   <= dbs_pkg::MINP_RST;
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_n      <= '0;
            r_ovf    <= 1'b0;
            r_i      <= '0;
            r_p      <= '0;
            r_js     <= '0;
            r_cnt    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_cid    <= '0;
            r_cc     <= '0;
            r_e      <= '0;
            r_enq    <= 1'b0;
            r_seed   <= 1'b0;
            r_lvalid <= '0;
            r_qmark  <= '0;
            o_strobe <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_addr == dbs_pkg::CFG_EPS) begin
                r_eps <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_addr == dbs_pkg::CFG_MINPTS) begin
                r_minp <= i_cfg_data[CW-1:0];
            end
            r_v0 <= issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (issue) begin
                r_js <= r_js + 1'b1;
            end
            if (lbl_we) begin
                r_lvalid[r_p] <= 1'b1;
            end
            // last pipeline stage acts on a neighbour hit
            if (r_v3 && r_hit) begin
                if (!r_enq) begin
                    r_cnt <= r_cnt + 1'b1;
                end else if (!r_qmark[r_j3] && r_tail < CW'(MAX_POINTS)) begin
                    r_qmark[r_j3] <= 1'b1;
                    r_tail        <= r_tail + 1'b1;
                end
            end
            o_strobe <= r_state == dbs_pkg::B_EMIT_OUT;
            case (r_state)
                dbs_pkg::B_IDLE: begin
                    if (i_job_valid) begin
                        r_n      <= i_job.n;
                        r_ovf    <= i_job.ovf;
                        r_i      <= '0;
                        r_cc     <= '0;
                        r_e      <= '0;
                        r_lvalid <= '0;
                        r_qmark  <= '0;
                    end
                end
                dbs_pkg::B_SCAN_CHK: begin
                    if (lbl_cur != dbs_pkg::LBL_UNCL) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_p    <= r_i[IW-1:0];
                        r_seed <= 1'b1;
                        r_enq  <= 1'b0;
                    end
                end
                dbs_pkg::B_PLAT: begin
                    r_js  <= '0;
                    r_cnt <= '0;
                end
                dbs_pkg::B_DECIDE: begin
                    if (!r_enq && core) begin
                        r_enq <= 1'b1;
                        r_js  <= '0;
                        if (r_seed) begin
                            r_cc   <= r_cc + 1'b1;
                            r_cid  <= r_cc + 1'b1;
                            r_head <= '0;
                            r_tail <= '0;
                        end
                    end else if (!r_enq && r_seed) begin
                        r_i <= r_i + 1'b1;
                    end
                end
                dbs_pkg::B_EXP: begin
                    if (r_head == r_tail) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_head <= r_head + 1'b1;
                    end
                end
                dbs_pkg::B_EXP_Q: begin
                    r_p <= r_qq;
                end
                dbs_pkg::B_EXP_L: begin
                    if (lbl_cur == dbs_pkg::LBL_UNCL) begin
                        r_seed <= 1'b0;
                        r_enq  <= 1'b0;
                    end
                end
                dbs_pkg::B_EMIT_OUT: begin
                    r_e <= r_e + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == dbs_pkg::B_EMIT_OUT) begin
            o_load_idx      <= 6'(r_e);
            o_cluster_label <= lbl_cur;
            o_cluster_count <= r_cc;
            o_overflow      <= r_ovf;
            o_last_label    <= (r_e + 1'b1 == r_n);
        end
    end

    assign o_active = r_state != dbs_pkg::B_IDLE;

endmodule

@@ design/dbscan_point_clustering.sv @@
// ----------------------------------------------------------------------------
// DBSCAN point clustering
// Loads a planar point set and labels each point with its cluster id.
// ----------------------------------------------------------------------------
// Usage: write eps_squared (index 0) and min_pts (index 1) on the config
// port while idle. Send one point per beat (start high, busy low); the beat
// with i_set_end closes the set, and up to MAX_POINTS points are kept, later
// ones dropped and flagged. After the closing beat busy rises and the
// engine clusters the set, then emits one label per point in load order,
// each on the result ports for one cycle under o_strobe, with a label read
// state between strobes. Clustering time is set by the single neighbour
// pipeline: every point gets one counting sweep over the n stored points
// and each core point one more.
// Reset clears the set in progress, the registers to 0 and 4, and the queue.
// Results cannot be held off; busy falls as the last label goes out.
// ----------------------------------------------------------------------------
`include "dbscan_point_clustering_assert.svh"

module dbscan_point_clustering #(
    parameter int MAX_POINTS = dbs_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = dbs_pkg::DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dbs_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [dbs_pkg::EPS_W-1:0]    i_cfg_data,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic                         i_set_end,
    output logic                         o_strobe,
    output logic [5:0]                   o_load_idx,
    output logic [dbs_pkg::CW-1:0]       o_cluster_label,
    output logic [dbs_pkg::CW-1:0]       o_cluster_count,
    output logic                         o_overflow,
    output logic                         o_last_label
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic          acc;
    logic          push;
    dbs_pkg::t_job push_job;
    logic          job_valid;
    dbs_pkg::t_job job;
    logic          job_pop;
    logic          active;
    logic [IW-1:0] rd_addr;
    logic signed [COORD_BITS-1:0] rd_x, rd_y;

    assign busy = job_valid | active;
    assign acc  = start & ~busy;

    dbs_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .i_set_end (i_set_end),
        .o_push    (push),
        .o_job     (push_job),
        .i_rd_addr (rd_addr),
        .o_rd_x    (rd_x),
        .o_rd_y    (rd_y)
    );

    dbs_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_job   (job)
    );

    dbs_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_job_valid     (job_valid),
        .i_job           (job),
        .o_job_pop       (job_pop),
        .o_active        (active),
        .o_rd_addr       (rd_addr),
        .i_rd_x          (rd_x),
        .i_rd_y          (rd_y),
        .o_strobe        (o_strobe),
        .o_load_idx      (o_load_idx),
        .o_cluster_label (o_cluster_label),
        .o_cluster_count (o_cluster_count),
        .o_overflow      (o_overflow),
        .o_last_label    (o_last_label)
    );

    `DBS_ASSERT_NEXT(a_set_end_busy, i_clk, i_rst_n, acc && i_set_end, busy, "no busy")
    `DBS_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_strobe && o_last_label, !o_strobe, "late beat")
    `DBS_ASSERT_NOW(a_label_range, i_clk, i_rst_n, o_strobe, o_cluster_label <= o_cluster_count, "label")

endmodule

@@ dv/dbscan_point_clustering_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DBSCAN point clustering testbench
// Loads point sets through the command port and clusters each set in a local
// predictor. Every label beat is checked against the predicted label, the
// cluster count, the overflow flag and the last flag. Registers are rewritten
// between sets, the extremes among them.
// ----------------------------------------------------------------------------
module dbscan_point_clustering_test;

    localparam int NPTS   = dbs_pkg::DEF_MAX_POINTS;
    localparam int CW     = dbs_pkg::CW;
    localparam int CFG_AW = dbs_pkg::CFG_AW;
    localparam int EPS_W  = dbs_pkg::EPS_W;

    typedef struct {
        logic [5:0]    idx;
        logic [CW-1:0] lbl;
        logic [CW-1:0] cnt;
        logic          ovf;
        logic          last;
    } t_label_beat;

    typedef struct {
        bit               is_reg;
        logic [CFG_AW-1:0] reg_idx;
        longint           reg_val;
        int               x;
        int               y;
        bit               set_end;
        bit               all_noise;   // labels known at a glance: all noise
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_AW-1:0]    i_cfg_addr;
    logic [EPS_W-1:0]     i_cfg_data;
    logic                 start;
    logic                 busy;
    logic signed [15:0]   i_coord_x;
    logic signed [15:0]   i_coord_y;
    logic                 i_set_end;
    logic                 o_strobe;
    logic [5:0]           o_load_idx;
    logic [CW-1:0]        o_cluster_label;
    logic [CW-1:0]        o_cluster_count;
    logic                 o_overflow;
    logic                 o_last_label;

    // predictor state
    longint               eps_sq;
    int                   min_nbrs;
    logic signed [15:0]   pt_x [NPTS];
    logic signed [15:0]   pt_y [NPTS];
    int                   n_loaded;
    bit                   pts_dropped;
    int                   lbl_of [NPTS];

    t_label_beat          label_q [$];
    int                   n_errors;
    int                   n_sets;
    int                   n_labels;
    int                   n_ovf_sets;
    int                   n_items;
    bit                   no_idle;

    dbscan_point_clustering uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .start(start), .busy(busy),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_set_end(i_set_end),
        .o_strobe(o_strobe), .o_load_idx(o_load_idx),
        .o_cluster_label(o_cluster_label), .o_cluster_count(o_cluster_count),
        .o_overflow(o_overflow), .o_last_label(o_last_label)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic bit is_near(int a, int b);
        longint dx, dy;
        if (a == b) return 1'b0;
        dx = longint'(pt_x[a]) - longint'(pt_x[b]);
        dy = longint'(pt_y[a]) - longint'(pt_y[b]);
        return (dx * dx + dy * dy) < eps_sq;
    endfunction

    function automatic int nbr_count(int p);
        int c;
        c = 0;
        for (int j = 0; j < n_loaded; j++) if (is_near(p, j)) c++;
        return c;
    endfunction

    // breadth-first growth from each unlabelled core point; returns cluster count
    function automatic int cluster_points();
        int  work [$];
        bit  queued [NPTS];
        int  k, ids;
        ids = 0;
        for (int i = 0; i < NPTS; i++) begin
            lbl_of[i] = int'(dbs_pkg::LBL_UNCL);
            queued[i] = 1'b0;
        end
        for (int i = 0; i < n_loaded; i++) begin
            if (lbl_of[i] != int'(dbs_pkg::LBL_UNCL)) continue;
            if (nbr_count(i) < min_nbrs) begin
                lbl_of[i] = int'(dbs_pkg::LBL_NOISE);
                continue;
            end
            ids++;
            lbl_of[i] = ids;
            work.delete();
            for (int j = 0; j < n_loaded; j++)
                if (!queued[j] && is_near(i, j)) begin
                    queued[j] = 1'b1;
                    work.push_back(j);
                end
            while (work.size() != 0) begin
                k = work.pop_front();
                if (lbl_of[k] == int'(dbs_pkg::LBL_NOISE)) begin
                    lbl_of[k] = ids;
                end else if (lbl_of[k] == int'(dbs_pkg::LBL_UNCL)) begin
                    lbl_of[k] = ids;
                    if (nbr_count(k) >= min_nbrs)
                        for (int j = 0; j < n_loaded; j++)
                            if (!queued[j] && is_near(k, j)) begin
                                queued[j] = 1'b1;
                                work.push_back(j);
                            end
                end
            end
        end
        return ids;
    endfunction

    // store one accepted point; on the closing beat queue the labels
    function automatic void take_point(int x, int y, bit e, bit all_noise);
        t_label_beat b;
        int          ids;
        n_items++;
        if (n_loaded < NPTS) begin
            pt_x[n_loaded] = 16'(x);
            pt_y[n_loaded] = 16'(y);
            n_loaded++;
        end else begin
            pts_dropped = 1'b1;
        end
        if (!e) return;
        ids = cluster_points();
        if (all_noise) ids = 0;
        for (int i = 0; i < n_loaded; i++) begin
            b.idx  = 6'(i);
            b.lbl  = all_noise ? dbs_pkg::LBL_NOISE : CW'(lbl_of[i]);
            b.cnt  = CW'(ids);
            b.ovf  = pts_dropped;
            b.last = (i == n_loaded - 1);
            label_q.push_back(b);
        end
        n_sets++;
        if (pts_dropped) n_ovf_sets++;
        n_loaded = 0;
        pts_dropped = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_label_beat b;
        if (i_rst_n && o_strobe) begin
            if (label_q.size() == 0) begin
                $error("label beat with nothing expected, index %0d", o_load_idx);
                n_errors++;
            end else begin
                b = label_q.pop_front();
                n_labels++;
                if (o_load_idx !== b.idx) begin
                    $error("load_idx exp %0d got %0d", b.idx, o_load_idx);
                    n_errors++;
                end
                if (o_cluster_label !== b.lbl) begin
                    $error("cluster_label exp %0d got %0d", b.lbl, o_cluster_label);
                    n_errors++;
                end
                if (o_cluster_count !== b.cnt) begin
                    $error("cluster_count exp %0d got %0d", b.cnt, o_cluster_count);
                    n_errors++;
                end
                if (o_overflow !== b.ovf) begin
                    $error("overflow exp %0d got %0d", b.ovf, o_overflow);
                    n_errors++;
                end
                if (o_last_label !== b.last) begin
                    $error("last_label exp %0d got %0d", b.last, o_last_label);
                    n_errors++;
                end
            end
        end
    end

    // hold start high until the beat is taken
    task automatic send_point(int x, int y, bit e, bit all_noise);
        if (!no_idle && $urandom_range(0, 99) < 11) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_coord_x <= 16'(x);
        i_coord_y <= 16'(y);
        i_set_end <= e;
        do @(posedge i_clk); while (busy);
        take_point(x, y, e, all_noise);
    endtask

    // let all labels drain and the engine settle before touching registers
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (label_q.size() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, longint val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= EPS_W'(val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == dbs_pkg::CFG_EPS) eps_sq = val;
        else                         min_nbrs = int'(val);
    endtask

    task automatic random_set(int n, bit tight);
        int cx [3];
        int sp;
        sp = $urandom_range(1, 40);
        for (int c = 0; c < 3; c++) begin
            cx[c] = $urandom_range(0, 60000) - 30000;
        end
        for (int i = 0; i < n; i++) begin
            if (tight && $urandom_range(0, 9) < 8)
                send_point(cx[i % 3] + $urandom_range(0, 2 * sp) - sp,
                           cx[(i + 1) % 3] + $urandom_range(0, 2 * sp) - sp,
                           i == n - 1, 1'b0);
            else
                send_point($urandom_range(0, 65535) - 32768,
                           $urandom_range(0, 65535) - 32768, i == n - 1, 1'b0);
        end
    endtask

    t_stim_row dir_tab [] = '{
        '{0, dbs_pkg::CFG_EPS, 0,  32767,  32767, 0, 1},
        '{0, dbs_pkg::CFG_EPS, 0, -32768, -32768, 0, 1},
        '{0, dbs_pkg::CFG_EPS, 0,      0,      0, 1, 1},
        '{0, dbs_pkg::CFG_EPS, 0,     -1,      1, 1, 1},
        '{1, dbs_pkg::CFG_EPS, 100,    0,      0, 0, 0},
        '{1, dbs_pkg::CFG_MINPTS, 0,   0,      0, 0, 0},
        '{0, dbs_pkg::CFG_EPS, 0,      0,      0, 0, 0},
        '{0, dbs_pkg::CFG_EPS, 0,      5,      0, 0, 0},
        '{0, dbs_pkg::CFG_EPS, 0,   1000,   1000, 0, 0},
        '{0, dbs_pkg::CFG_EPS, 0,  30000, -30000, 1, 0},
        '{1, dbs_pkg::CFG_EPS, 50,     0,      0, 0, 0},
        '{1, dbs_pkg::CFG_MINPTS, 2,   0,      0, 0, 0},
        '{0, dbs_pkg::CFG_EPS, 0,     -7,      0, 0, 0},
        '{0, dbs_pkg::CFG_EPS, 0,      0,      0, 0, 0},
        '{0, dbs_pkg::CFG_EPS, 0,      4,      0, 0, 0},
        '{0, dbs_pkg::CFG_EPS, 0,      8,      0, 0, 0},
        '{0, dbs_pkg::CFG_EPS, 0,     40,     40, 0, 0},
        '{0, dbs_pkg::CFG_EPS, 0,     12,      0, 1, 0},
        '{1, dbs_pkg::CFG_EPS, 64'h7_FFFF_FFFF, 0, 0, 0, 0},
        '{1, dbs_pkg::CFG_MINPTS, 64,  0,      0, 0, 0},
        '{0, dbs_pkg::CFG_EPS, 0, -32768,  32767, 0, 1},
        '{0, dbs_pkg::CFG_EPS, 0,  32767, -32768, 0, 1},
        '{0, dbs_pkg::CFG_EPS, 0,  21845, -21846, 1, 1}
    };

    initial begin
        int n;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = dbs_pkg::CFG_EPS;
        i_cfg_data = '0;
        start      = 1'b0;
        i_coord_x  = '0;
        i_coord_y  = '0;
        i_set_end  = 1'b0;
        eps_sq     = 0;
        min_nbrs   = int'(dbs_pkg::MINP_RST);
        n_loaded   = 0;
        pts_dropped = 1'b0;
        n_errors = 0; n_sets = 0; n_labels = 0; n_ovf_sets = 0; n_items = 0;
        no_idle  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].is_reg) begin
                drain();
                write_reg(dir_tab[r].reg_idx, dir_tab[r].reg_val);
            end else begin
                send_point(dir_tab[r].x, dir_tab[r].y, dir_tab[r].set_end,
                           dir_tab[r].all_noise);
            end
        end

        while (n_items < 420) begin
            if (n_sets % 3 == 0) begin
                drain();
                case ((n_sets / 3) % 6)
                    0: write_reg(dbs_pkg::CFG_EPS, 0);
                    1: write_reg(dbs_pkg::CFG_EPS, 64'h7_FFFF_FFFF);
                    default: write_reg(dbs_pkg::CFG_EPS, $urandom_range(0, 2500));
                endcase
                case ((n_sets / 3) % 5)
                    0: write_reg(dbs_pkg::CFG_MINPTS, 0);
                    1: write_reg(dbs_pkg::CFG_MINPTS, 64);
                    default: write_reg(dbs_pkg::CFG_MINPTS, $urandom_range(1, 5));
                endcase
            end
            no_idle = (n_items > 180 && n_items < 280);
            n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70)
                                            : $urandom_range(1, 12);
            random_set(n, $urandom_range(0, 9) < 7);
            // pause once with nothing in flight
            if (n_sets == 20) drain();
        end

        start <= 1'b0;
        do @(posedge i_clk); while (label_q.size() != 0);
        repeat (50) @(posedge i_clk);
        $display("Covered %0d points in %0d sets, %0d labels checked, %0d sets with drops.",
                 n_items, n_sets, n_labels, n_ovf_sets);
        if (n_errors == 0 && label_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
